### rtl/rrq_pkg.sv
// rrq_pkg: shared types and codes for the round-robin ready queue.
// Used by rrq_cell, round_robin_ready_queue_top and rrq_checker.
package rrq_pkg;

  localparam int KIND_W      = 2;
  localparam int ID_OUT_W    = 16;
  localparam int COUNT_OUT_W = 7;
  localparam int STATUS_W    = 2;
  localparam int OUT_DATA_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_START  = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_FULL      = 2'd1,
    STAT_NOT_FOUND = 2'd2,
    STAT_NO_EFFECT = 2'd3
  } status_t;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_EXEC   = 6'b000010,
    ST_PREFIX = 6'b000100,
    ST_SHIFT  = 6'b001000,
    ST_SELECT = 6'b010000,
    ST_FINISH = 6'b100000
  } state_t;

  // Per-cycle commands broadcast to every cell of the row
  typedef struct packed {
    logic write;    // load key into the cell addressed by wr_addr
    logic compare;  // capture key match flag
    logic capture;  // capture shift flag from the prefix network
    logic shift;    // flagged cells take their upper neighbor's id
  } cell_ctl_t;

endpackage

### rtl/round_robin_ready_queue_top.sv
// round_robin_ready_queue_top: compacting ready queue of task ids with a
// round-robin pointer. Depends on rrq_pkg, rrq_cell and rrq_prefix.
//
//  channel   dir  tdata                                        tuser
//  s_axis    in   [15:0] task_id                               [1:0] kind
//  m_axis    out  [15:0] current_id, [16] current_valid,       -
//                 [23:17] queue_count, [25:24] status, 0 pad
//
// Add and start go from exec to finish; tick goes through exec, select and finish
// (exec and finish when it has no effect), remove through exec, prefix, shift
// and finish; the slot row does its search, prefix and shift in those states.
// s_axis_tready is high only when no item is in flight; a result waiting on
// m_axis holds the next item at its last step until the output frees.
// rst is synchronous; the id slots carry no reset and are read only below
// the fill count.
module round_robin_ready_queue_top #(
  parameter int QUEUE_DEPTH = 64,
  parameter int ID_WIDTH    = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [15:0]                      s_axis_tdata,  // [15:0] task_id
  input  logic [rrq_pkg::KIND_W-1:0]       s_axis_tuser,  // [1:0] kind
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] current_id, [16] current_valid, [23:17] queue_count, [25:24] status
  output logic [rrq_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);
  import rrq_pkg::*;

  localparam int KEEP_W  = (ID_WIDTH < ID_OUT_W) ? ID_WIDTH : ID_OUT_W;
  localparam int IDX_W   = $clog2(QUEUE_DEPTH);
  localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

  state_t            state;
  kind_t             kind_q;
  logic [KEEP_W-1:0] key_q;
  logic [COUNT_W-1:0] count;
  logic [IDX_W-1:0]  rr;
  logic [KEEP_W-1:0] run_id;
  logic              run_valid;
  logic              tick_en;
  status_t           status_q;
  logic              found_q;

  cell_ctl_t         ctl;
  logic [KEEP_W-1:0] cell_id [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] match_vec;
  logic [QUEUE_DEPTH-1:0] pfx_vec;
  logic [KEEP_W-1:0] sel_id;
  logic [COUNT_W-1:0] rr_inc;
  logic [COUNT_W-1:0] count_dec;
  logic              out_free;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [KEEP_W-1:0] upper;
    if (i < QUEUE_DEPTH - 1) begin : g_up
      assign upper = cell_id[i+1];
    end else begin : g_top
      assign upper = cell_id[i];
    end
    rrq_cell #(
      .ID_W    (KEEP_W),
      .IDX_W   (IDX_W),
      .COUNT_W (COUNT_W),
      .INDEX   (i)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .key      (key_q),
      .wr_addr  (count[IDX_W-1:0]),
      .count    (count),
      .upper_id (upper),
      .pfx_in   (pfx_vec[i]),
      .id       (cell_id[i]),
      .match    (match_vec[i])
    );
  end

  rrq_prefix #(.WIDTH(QUEUE_DEPTH)) u_prefix (
    .req (match_vec),
    .pfx (pfx_vec)
  );

  // one-hot read of the slot under the round-robin pointer
  always_comb begin
    sel_id = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      if (rr == IDX_W'(i)) sel_id = sel_id | cell_id[i];
    end
  end

  assign rr_inc    = COUNT_W'(rr) + COUNT_W'(1);
  assign count_dec = count - COUNT_W'(1);
  assign out_free  = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE);

  always_comb begin
    ctl = '0;
    case (state)
      ST_EXEC: begin
        ctl.write   = (kind_q == KIND_ADD) && (count != COUNT_W'(QUEUE_DEPTH));
        ctl.compare = (kind_q == KIND_REMOVE);
      end
      ST_PREFIX: ctl.capture = 1'b1;
      ST_SHIFT:  ctl.shift   = found_q;
      default:   ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      count         <= '0;
      rr            <= '0;
      run_id        <= '0;
      run_valid     <= 1'b0;
      tick_en       <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if ((state == ST_FINISH) && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            kind_q <= kind_t'(s_axis_tuser);
            key_q  <= s_axis_tdata[KEEP_W-1:0];
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          case (kind_q)
            KIND_ADD: begin
              state <= ST_FINISH;
              if (count == COUNT_W'(QUEUE_DEPTH)) begin
                status_q <= STAT_FULL;
              end else begin
                status_q <= STAT_DONE;
                count    <= count + COUNT_W'(1);
                if (count == '0) begin
                  run_id    <= key_q;
                  run_valid <= 1'b1;
                  rr        <= '0;
                end
              end
            end
            KIND_REMOVE: begin
              status_q <= STAT_DONE;
              state    <= ST_PREFIX;
            end
            KIND_TICK: begin
              if (!tick_en || count <= COUNT_W'(1)) begin
                status_q <= STAT_NO_EFFECT;
                state    <= ST_FINISH;
              end else begin
                status_q <= STAT_DONE;
                rr       <= (rr_inc >= count) ? '0 : rr_inc[IDX_W-1:0];
                state    <= ST_SELECT;
              end
            end
            KIND_START: begin
              state <= ST_FINISH;
              if (count == '0) begin
                status_q <= STAT_NO_EFFECT;
              end else begin
                status_q  <= STAT_DONE;
                run_id    <= cell_id[0];
                run_valid <= 1'b1;
                tick_en   <= 1'b1;
              end
            end
            default: begin
              status_q <= STAT_NO_EFFECT;
              state    <= ST_FINISH;
            end
          endcase
        end
        ST_PREFIX: begin
          found_q <= pfx_vec[QUEUE_DEPTH-1];
          state   <= ST_SHIFT;
        end
        ST_SHIFT: begin
          if (found_q) begin
            count <= count_dec;
            if ((COUNT_W'(rr) >= count_dec) && (count_dec != '0)) rr <= '0;
          end else begin
            status_q <= STAT_NOT_FOUND;
          end
          state <= ST_FINISH;
        end
        ST_SELECT: begin
          run_id    <= sel_id;
          run_valid <= 1'b1;
          state     <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result payload, loaded on the same edge that raises m_axis_tvalid
  always_ff @(posedge clk) begin
    if ((state == ST_FINISH) && out_free) begin
      m_axis_tdata <= {
        {(OUT_DATA_W - ID_OUT_W - 1 - COUNT_OUT_W - STATUS_W){1'b0}},
        status_q,
        COUNT_OUT_W'(count),
        run_valid,
        ID_OUT_W'(run_id)
      };
    end
  end

endmodule

### rtl/rrq_cell.sv
// rrq_cell: one queue slot holding a task id, with match and shift flags.
// Depends on rrq_pkg for the cell command struct.
module rrq_cell #(
  parameter int ID_W    = 16,
  parameter int IDX_W   = 6,
  parameter int COUNT_W = 7,
  parameter int INDEX   = 0
) (
  input  logic               clk,
  input  rrq_pkg::cell_ctl_t ctl,
  input  logic [ID_W-1:0]    key,
  input  logic [IDX_W-1:0]   wr_addr,
  input  logic [COUNT_W-1:0] count,
  input  logic [ID_W-1:0]    upper_id,
  input  logic               pfx_in,
  output logic [ID_W-1:0]    id,
  output logic               match
);
  import rrq_pkg::*;

  logic shift_q;

  always_ff @(posedge clk) begin
    if (ctl.write && (wr_addr == IDX_W'(INDEX))) begin
      id <= key;
    end else if (ctl.shift && shift_q) begin
      id <= upper_id;
    end
    if (ctl.compare) begin
      // only occupied slots may match
      match <= (id == key) && (COUNT_W'(INDEX) < count);
    end
    if (ctl.capture) begin
      shift_q <= pfx_in;
    end
  end

endmodule

### rtl/rrq_prefix.sv
// rrq_prefix: log-depth prefix OR over the row of match flags.
// Standalone; marks every slot at or above the first match.
module rrq_prefix #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0] req,
  output logic [WIDTH-1:0] pfx
);
  localparam int LEVELS = $clog2(WIDTH);

  logic [WIDTH-1:0] lvl [LEVELS+1];

  assign lvl[0] = req;

  for (genvar k = 0; k < LEVELS; k++) begin : g_lvl
    for (genvar i = 0; i < WIDTH; i++) begin : g_bit
      if (i >= (1 << k)) begin : g_or
        assign lvl[k+1][i] = lvl[k][i] | lvl[k][i-(1<<k)];
      end else begin : g_pass
        assign lvl[k+1][i] = lvl[k][i];
      end
    end
  end

  assign pfx = lvl[LEVELS];

endmodule

### rtl/rrq_checker.sv
// rrq_checker: port-level checks on round_robin_ready_queue_top, with bind.
// Depends on rrq_pkg for widths.
module rrq_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic [15:0]                    s_axis_tdata,
  input logic [rrq_pkg::KIND_W-1:0]     s_axis_tuser,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [rrq_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
  import rrq_pkg::*;

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // a waiting input transfer keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && !s_axis_tready |=>
      s_axis_tvalid && $stable(s_axis_tdata) && $stable(s_axis_tuser))
    else $error("input changed while waiting");

  // stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one item in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  // a nonempty queue always has a selected task
  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[ID_OUT_W] |-> m_axis_tdata[23:17] == '0)
    else $error("ids held with no current task");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind round_robin_ready_queue_top rrq_checker u_rrq_checker (.*);

### tb/tb_round_robin_ready_queue_top.sv
// Self-checking bench for round_robin_ready_queue_top: add, remove, tick and
// start events are streamed in and each result is checked against a predictor
// of the id queue. Depends on rrq_pkg and the RTL of the block.
`timescale 1ns / 100ps

module tb_round_robin_ready_queue_top;
  import rrq_pkg::*;

  localparam int SLOTS      = 64;
  localparam int RAND_ITEMS = 750;
  localparam int POOL_SIZE  = 12;

  typedef struct {
    kind_t       kind;
    logic [15:0] id;
    bit          hold;  // wait for every outstanding result before this transfer
  } sched_event_t;

  typedef struct packed {
    logic [15:0] current_id;
    logic        current_valid;
    logic [6:0]  count;
    status_t     status;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] task_id
  logic [1:0]  s_axis_tuser = '0;   // [1:0] kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [15:0] current_id, [16] current_valid, [23:17] queue_count, [25:24] status
  logic [31:0] m_axis_tdata;

  sched_event_t  event_q[$];
  sched_result_t sched_outcomes_q[$];
  logic [15:0]   id_pool[POOL_SIZE];
  int            errors = 0;
  int            sent = 0;

  // predictor state
  logic [15:0] slot_ids[SLOTS];
  int          held = 0;
  int          rr = 0;
  logic [15:0] run_id = '0;
  logic        run_valid = 1'b0;
  logic        ticking = 1'b0;

  round_robin_ready_queue_top dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic sched_result_t apply_sched_event(kind_t kind, logic [15:0] id);
    sched_result_t r;
    status_t       st;
    int            hit;
    st = STAT_DONE;
    case (kind)
      KIND_ADD: begin
        if (held >= SLOTS) begin
          st = STAT_FULL;
        end else begin
          slot_ids[held] = id;
          held++;
          if (held == 1) begin
            run_id    = id;
            run_valid = 1'b1;
            rr        = 0;
          end
        end
      end
      KIND_REMOVE: begin
        hit = -1;
        for (int i = 0; i < held; i++)
          if (hit < 0 && slot_ids[i] == id) hit = i;
        if (hit < 0) begin
          st = STAT_NOT_FOUND;
        end else begin
          for (int j = hit; j + 1 < held; j++) slot_ids[j] = slot_ids[j + 1];
          held--;
          // current id stays as it was even if it was the one removed
          if (rr >= held && held > 0) rr = 0;
        end
      end
      KIND_TICK: begin
        if (!ticking || held <= 1) begin
          st = STAT_NO_EFFECT;
        end else begin
          rr        = (rr + 1 >= held) ? 0 : rr + 1;
          run_id    = slot_ids[rr];
          run_valid = 1'b1;
        end
      end
      default: begin
        if (held == 0) begin
          st = STAT_NO_EFFECT;
        end else begin
          run_id    = slot_ids[0];
          run_valid = 1'b1;
          ticking   = 1'b1;
        end
      end
    endcase
    r.current_id    = run_id;
    r.current_valid = run_valid;
    r.count         = held[6:0];
    r.status        = st;
    return r;
  endfunction

  function automatic void push_event(kind_t kind, logic [15:0] id, bit hold = 1'b0);
    sched_event_t ev;
    ev.kind = kind;
    ev.id   = id;
    ev.hold = hold;
    event_q.push_back(ev);
  endfunction

  // mostly ids from a small pool so removes hit and duplicates pile up
  function automatic logic [15:0] pick_id();
    if ($urandom_range(99) < 85) return id_pool[$urandom_range(POOL_SIZE - 1)];
    return 16'($urandom);
  endfunction

  function automatic bit take_break();
    if (sent >= 300 && sent < 450) return 1'b0;
    return $urandom_range(99) < 31;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (s_axis_tvalid) begin
        sched_outcomes_q.push_back(apply_sched_event(kind_t'(s_axis_tuser), s_axis_tdata));
        sent++;
      end
      if (event_q.size() != 0 && !take_break() &&
          !(event_q[0].hold && (sched_outcomes_q.size() != 0 || s_axis_tvalid))) begin
        s_axis_tdata  <= event_q[0].id;
        s_axis_tuser  <= event_q[0].kind;
        s_axis_tvalid <= 1'b1;
        void'(event_q.pop_front());
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (sched_outcomes_q.size() == 0) begin
          $error("result transfer with nothing expected: tdata %08h", m_axis_tdata);
          errors++;
        end else begin
          sched_result_t want;
          want = sched_outcomes_q.pop_front();
          if (m_axis_tdata[15:0] !== want.current_id) begin
            $error("current_id: expected %04h, got %04h", want.current_id, m_axis_tdata[15:0]);
            errors++;
          end
          if (m_axis_tdata[16] !== want.current_valid) begin
            $error("current_valid: expected %0b, got %0b", want.current_valid, m_axis_tdata[16]);
            errors++;
          end
          if (m_axis_tdata[23:17] !== want.count) begin
            $error("queue_count: expected %0d, got %0d", want.count, m_axis_tdata[23:17]);
            errors++;
          end
          if (m_axis_tdata[25:24] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[25:24]);
            errors++;
          end
        end
      end
      m_axis_tready <= !take_break();
    end
  end

  initial begin
    int total;
    int n;
    int n_items;
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 16'($urandom);

    // directed: empty queue, first add, ticking before and after start,
    // wrap, removal of current and of absent ids, emptying, repeated start
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_START, 16'hFFFF);
    push_event(KIND_REMOVE, 16'h0000);
    push_event(KIND_ADD, 16'h0000);
    push_event(KIND_ADD, 16'hFFFF);
    push_event(KIND_TICK, 16'h1111);
    push_event(KIND_START, 16'h0000);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_ADD, 16'h5A5A);
    push_event(KIND_ADD, 16'hA5A5);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_REMOVE, 16'hA5A5);
    push_event(KIND_REMOVE, 16'h1234);
    push_event(KIND_REMOVE, 16'h0000);
    push_event(KIND_REMOVE, 16'hFFFF);
    push_event(KIND_REMOVE, 16'h5A5A);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_ADD, 16'h0001);
    push_event(KIND_TICK, 16'h0000);
    push_event(KIND_START, 16'h0000);
    push_event(KIND_START, 16'h0000);

    // random phases: fill to overflow, mixed churn, drain; first one fills
    total = 0;
    n = 0;
    while (total < RAND_ITEMS) begin
      case ((n == 0) ? 0 : $urandom_range(2))
        0: begin
          repeat ($urandom_range(60, 72)) begin
            if ($urandom_range(9) == 0) push_event(KIND_TICK, 16'($urandom));
            else push_event(KIND_ADD, pick_id());
            total++;
          end
        end
        1: begin
          repeat ($urandom_range(20, 40)) begin
            case ($urandom_range(9))
              0, 1, 2: push_event(KIND_ADD, pick_id());
              3, 4, 5: push_event(KIND_REMOVE, pick_id());
              6, 7, 8: push_event(KIND_TICK, 16'($urandom));
              default: push_event(KIND_START, 16'($urandom));
            endcase
            total++;
          end
        end
        default: begin
          repeat ($urandom_range(20, 70)) begin
            if ($urandom_range(7) == 0) push_event(KIND_TICK, 16'($urandom));
            else push_event(KIND_REMOVE, pick_id());
            total++;
          end
        end
      endcase
      // the last event of one phase waits for the block to drain completely
      if (n == 4) event_q[event_q.size() - 1].hold = 1'b1;
      n++;
    end
    n_items = event_q.size();

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    while (sent < n_items || sched_outcomes_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("tb_round_robin_ready_queue_top passed");
    end else begin
      $display("tb_round_robin_ready_queue_top failed");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb_round_robin_ready_queue_top failed");
    $finish;
  end

endmodule

### files.f
rtl/rrq_pkg.sv
rtl/rrq_cell.sv
rtl/rrq_prefix.sv
rtl/round_robin_ready_queue_top.sv
rtl/rrq_checker.sv
tb/tb_round_robin_ready_queue_top.sv
